/* rtl/prmd_pkg.sv */
`timescale 1ns / 1ps
package prmd_pkg;

  // Widths of the configuration registers and the fixed result fields
  localparam int TILE_W     = 13;
  localparam int PAGES_W    = 11;
  localparam int OUT_W      = 16;
  localparam int SUM_W      = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register indexes of the configuration port; other indexes are dropped
  localparam logic [CFG_IDX_W-1:0] REG_TILE_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_TOTAL  = 2'd1;

  // Register reset values
  localparam logic [TILE_W-1:0]  TILE_RESET  = 13'd4096;
  localparam logic [PAGES_W-1:0] PAGES_RESET = 11'd1024;

  // Saturation limit of a per-pixel sum
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

endpackage

/* rtl/prmd_ram.sv */
`timescale 1ns / 1ps
module prmd_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pixel_running_mean_deviation.sv */
`timescale 1ns / 1ps
// A pixel that is accepted passes the sum stage, each divider stage and the output
// register. Throughput: one pixel per cycle; the sum memory does one read and one write
// per cycle; the divider by the page count has a load stage, then 26 stages that each resolve
// one quotient bit. The whole pipeline holds while a result waits on the output.
// Reset: position, page count and valid bits clear, registers load 4096 and 1024;
// the sum memory is not cleared, the first page overwrites it.
module pixel_running_mean_deviation #(
  parameter int MAX_TILE_PIXELS = 4096,
  parameter int MAX_PAGES       = 1024,
  parameter int PIXEL_BITS      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prmd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [prmd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [PIXEL_BITS-1:0]               pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [prmd_pkg::OUT_W-1:0]          deviation_o,
  output logic [prmd_pkg::OUT_W-1:0]          mean_o,
  output logic                                final_page_o
);

  localparam int SUM_W  = prmd_pkg::SUM_W;
  localparam int OUT_W  = prmd_pkg::OUT_W;
  localparam int ADDR_W = $clog2(MAX_TILE_PIXELS);
  localparam int PAGE_W = $clog2(MAX_PAGES);
  localparam int DIV_W  = PAGE_W + 1;
  localparam int TCMP_W = (ADDR_W + 1 > prmd_pkg::TILE_W) ? ADDR_W + 1 : prmd_pkg::TILE_W;
  localparam int PCMP_W = (PAGE_W + 1 > prmd_pkg::PAGES_W) ? PAGE_W + 1 : prmd_pkg::PAGES_W;
  localparam int DIF_W  = (SUM_W > PIXEL_BITS) ? SUM_W : PIXEL_BITS;
  localparam int ACC_W  = DIF_W + 1;
  localparam int NSTG   = SUM_W;

  // Configuration
  logic [prmd_pkg::TILE_W-1:0]  tile_q;
  logic [prmd_pkg::PAGES_W-1:0] pages_q;
  logic [TCMP_W-1:0]            eff_tile;
  logic [PCMP_W-1:0]            eff_pages;

  // Position and page counters
  logic [ADDR_W-1:0] pos_q;
  logic [PAGE_W-1:0] page_q;
  logic              pos_wrap;
  logic              last_page;

  logic adv;
  logic accept;

  // Stage 1: sum update against the memory
  logic                  s1_vld_q;
  logic [PIXEL_BITS-1:0] s1_px_q;
  logic [ADDR_W-1:0]     s1_pos_q;
  logic                  s1_first_q;
  logic                  s1_last_q;
  logic [DIV_W-1:0]      s1_dvs_q;
  logic                  fwd_hit_q;
  logic [SUM_W-1:0]      fwd_sum_q;
  logic [SUM_W-1:0]      ram_rdata;
  logic [SUM_W-1:0]      s1_base;
  logic [ACC_W-1:0]      s1_raw;
  logic [SUM_W-1:0]      s1_sum;

  // Divider pipeline
  logic [NSTG:0]         dv_vld_q;
  logic [SUM_W-1:0]      dv_dq_q   [NSTG+1];
  logic [PIXEL_BITS-1:0] dv_px_q   [NSTG+1];
  logic                  dv_last_q [NSTG+1];
  logic [DIV_W-1:0]      dv_rem_q  [NSTG];
  logic [DIV_W-1:0]      dv_dvs_q  [NSTG];

  // Output register
  logic             out_valid_q;
  logic [OUT_W-1:0] deviation_q;
  logic [OUT_W-1:0] mean_q;
  logic             final_q;
  logic [DIF_W-1:0] fin_px;
  logic [DIF_W-1:0] fin_mean;
  logic [DIF_W-1:0] fin_dev;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q  <= prmd_pkg::TILE_RESET;
      pages_q <= prmd_pkg::PAGES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prmd_pkg::REG_TILE_PIXELS: tile_q  <= cfg_data_i[prmd_pkg::TILE_W-1:0];
        prmd_pkg::REG_PAGE_TOTAL:  pages_q <= cfg_data_i[prmd_pkg::PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to the usable range
  always_comb begin
    if (tile_q == '0) begin
      eff_tile = TCMP_W'(1);
    end else if (TCMP_W'(tile_q) > TCMP_W'(MAX_TILE_PIXELS)) begin
      eff_tile = TCMP_W'(MAX_TILE_PIXELS);
    end else begin
      eff_tile = TCMP_W'(tile_q);
    end
    if (pages_q == '0) begin
      eff_pages = PCMP_W'(1);
    end else if (PCMP_W'(pages_q) > PCMP_W'(MAX_PAGES)) begin
      eff_pages = PCMP_W'(MAX_PAGES);
    end else begin
      eff_pages = PCMP_W'(pages_q);
    end
  end

  assign pos_wrap  = (TCMP_W'(pos_q) + TCMP_W'(1)) >= eff_tile;
  assign last_page = (PCMP_W'(page_q) + PCMP_W'(1)) >= eff_pages;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      page_q <= '0;
    end else if (accept) begin
      if (pos_wrap) begin
        pos_q  <= '0;
        page_q <= last_page ? '0 : page_q + PAGE_W'(1);
      end else begin
        pos_q <= pos_q + ADDR_W'(1);
      end
    end
  end

  prmd_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_TILE_PIXELS)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (adv && s1_vld_q),
    .waddr_i(s1_pos_q),
    .wdata_i(s1_sum),
    .re_i   (adv),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  // Take the sum written in the same cycle the read went out
  assign s1_base = fwd_hit_q ? fwd_sum_q : ram_rdata;

  always_comb begin
    if (s1_first_q) begin
      s1_raw = ACC_W'(s1_px_q);
    end else begin
      s1_raw = ACC_W'(s1_base) + ACC_W'(s1_px_q);
    end
    if (s1_raw > ACC_W'(prmd_pkg::SUM_MAX)) begin
      s1_sum = prmd_pkg::SUM_MAX;
    end else begin
      s1_sum = s1_raw[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= accept;
      fwd_hit_q <= accept && s1_vld_q && (pos_q == s1_pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q    <= pixel_i;
      s1_pos_q   <= pos_q;
      s1_first_q <= (page_q == '0);
      s1_last_q  <= last_page;
      s1_dvs_q   <= DIV_W'(page_q) + DIV_W'(1);
      fwd_sum_q  <= s1_sum;
    end
  end

  // Divider: stage 0 loads the sum, each later stage resolves one quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (adv) begin
      dv_vld_q <= {dv_vld_q[NSTG-1:0], s1_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_dq_q[0]   <= s1_sum;
      dv_rem_q[0]  <= '0;
      dv_dvs_q[0]  <= s1_dvs_q;
      dv_px_q[0]   <= s1_px_q;
      dv_last_q[0] <= s1_last_q;
    end
  end

  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] rem_d;

    assign trial = {dv_rem_q[k-1], dv_dq_q[k-1][SUM_W-1]};
    assign diff  = trial - {1'b0, dv_dvs_q[k-1]};
    assign ge    = trial >= {1'b0, dv_dvs_q[k-1]};
    assign rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_dq_q[k]   <= {dv_dq_q[k-1][SUM_W-2:0], ge};
        dv_px_q[k]   <= dv_px_q[k-1];
        dv_last_q[k] <= dv_last_q[k-1];
      end
    end

    if (k < NSTG) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_rem_q[k] <= rem_d;
          dv_dvs_q[k] <= dv_dvs_q[k-1];
        end
      end
    end
  end

  assign fin_px   = DIF_W'(dv_px_q[NSTG]);
  assign fin_mean = DIF_W'(dv_dq_q[NSTG]);
  assign fin_dev  = (fin_px >= fin_mean) ? (fin_px - fin_mean) : (fin_mean - fin_px);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      deviation_q <= fin_dev[OUT_W-1:0];
      mean_q      <= fin_mean[OUT_W-1:0];
      final_q     <= dv_last_q[NSTG];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign deviation_o  = deviation_q;
  assign mean_o       = mean_q;
  assign final_page_o = final_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_vld_q)
    else $error("accepted request did not enter the sum stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(dv_vld_q) && $stable(s1_vld_q)))
    else $error("pipeline moved while the output was stalled");

  a_page_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pos_wrap && !last_page) |=> (page_q == $past(page_q) + PAGE_W'(1)))
    else $error("page count did not advance at the end of a page");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(dv_vld_q[NSTG]))
    else $error("result appeared without a request leaving the divider");

endmodule

/* sim/dark_deviation_checker.sv */
`timescale 1ns / 1ps
module dark_deviation_checker
  import prmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  input  logic [15:0]           pixel_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_W-1:0]      deviation_i,
  input  logic [OUT_W-1:0]      mean_i,
  input  logic                  final_page_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam int MAX_TILE  = 4096;
  localparam int MAX_PAGES = 1024;

  typedef struct packed {
    logic [OUT_W-1:0] deviation;
    logic [OUT_W-1:0] mean;
    logic             final_page;
  } dark_result_t;

  logic [TILE_W-1:0]  tile_cfg;
  logic [PAGES_W-1:0] pages_cfg;
  logic [SUM_W-1:0]   pixel_sums [MAX_TILE];
  int unsigned        position;
  int unsigned        page;
  dark_result_t       expected_q [$];
  int                 mismatches;
  int                 checked;

  // Fold one sample into its running sum and advance position and page count.
  function automatic dark_result_t accumulate_pixel(input logic [15:0] px);
    int unsigned  tiles;
    int unsigned  pages;
    int unsigned  total;
    int unsigned  avg;
    logic         last;
    dark_result_t r;
    tiles = (tile_cfg == 0) ? 1 : (tile_cfg > MAX_TILE) ? MAX_TILE : tile_cfg;
    pages = (pages_cfg == 0) ? 1 : (pages_cfg > MAX_PAGES) ? MAX_PAGES : pages_cfg;
    last = (page + 1 >= pages);
    // the first page overwrites whatever the store held
    total = (page == 0) ? px : pixel_sums[position] + px;
    if (total > SUM_MAX) total = SUM_MAX;
    pixel_sums[position] = total[SUM_W-1:0];
    avg = total / (page + 1);
    r.mean = avg[OUT_W-1:0];
    r.deviation = (px >= avg) ? OUT_W'(px - avg) : OUT_W'(avg - px);
    r.final_page = last;
    if (position + 1 >= tiles) begin
      position = 0;
      page = last ? 0 : page + 1;
    end else begin
      position = position + 1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dark_result_t want;
    dark_result_t got;
    if (!rst_ni) begin
      tile_cfg = TILE_RESET;
      pages_cfg = PAGES_RESET;
      position = 0;
      page = 0;
      expected_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TILE_PIXELS: tile_cfg = cfg_data_i[TILE_W-1:0];
          REG_PAGE_TOTAL:  pages_cfg = cfg_data_i[PAGES_W-1:0];
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) expected_q.push_back(accumulate_pixel(pixel_i));
      if (res_valid_i && res_ready_i) begin
        got = '{deviation_i, mean_i, final_page_i};
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request pending: deviation %0d mean %0d final %0b",
                   $time, got.deviation, got.mean, got.final_page);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.deviation !== want.deviation) begin
            $display("%0t: result %0d deviation expected %0d actual %0d",
                     $time, checked, want.deviation, got.deviation);
            mismatches++;
          end
          if (got.mean !== want.mean) begin
            $display("%0t: result %0d mean expected %0d actual %0d",
                     $time, checked, want.mean, got.mean);
            mismatches++;
          end
          if (got.final_page !== want.final_page) begin
            $display("%0t: result %0d final_page expected %0b actual %0b",
                     $time, checked, want.final_page, got.final_page);
            mismatches++;
          end
        end
        checked++;
      end
    end
    mismatches_o <= mismatches;
    pending_o <= expected_q.size();
    checked_o <= checked;
  end

endmodule

/* sim/pixel_running_mean_deviation_tb.sv */
`timescale 1ns / 1ps
module pixel_running_mean_deviation_tb;
  import prmd_pkg::*;

  localparam int MAX_TILE  = 4096;
  localparam int MAX_PAGES = 1024;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_TILE_PIXELS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic [15:0]           pixel = '0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [OUT_W-1:0]      deviation;
  logic [OUT_W-1:0]      mean;
  logic                  final_page;

  int mismatches;
  int pending;
  int checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int settings_used = 0;

  // Position and page mirror, kept only to steer tile changes away from
  // sums that were never stored.
  logic [TILE_W-1:0]  tile_set = TILE_RESET;
  logic [PAGES_W-1:0] pages_set = PAGES_RESET;
  int unsigned        track_pos = 0;
  int unsigned        track_page = 0;
  bit                 written [MAX_TILE];
  logic [15:0]        dark_level = 16'h0800;

  pixel_running_mean_deviation dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_i      (pixel),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .deviation_o  (deviation),
    .mean_o       (mean),
    .final_page_o (final_page)
  );

  dark_deviation_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_valid_i  (in_valid),
    .pix_ready_i  (in_ready),
    .pixel_i      (pixel),
    .res_valid_i  (out_valid),
    .res_ready_i  (out_ready),
    .deviation_i  (deviation),
    .mean_i       (mean),
    .final_page_i (final_page),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);

  function automatic int unsigned tile_limit(input logic [TILE_W-1:0] v);
    return (v == 0) ? 1 : (v > MAX_TILE) ? MAX_TILE : v;
  endfunction

  function automatic int unsigned page_limit(input logic [PAGES_W-1:0] v);
    return (v == 0) ? 1 : (v > MAX_PAGES) ? MAX_PAGES : v;
  endfunction

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(9, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(65535, 0));
      default: return dark_level + 16'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] px);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    written[track_pos] = 1'b1;
    if (track_pos + 1 >= tile_limit(tile_set)) begin
      track_pos = 0;
      track_page = (track_page + 1 >= page_limit(pages_set)) ? 0 : track_page + 1;
    end else begin
      track_pos++;
    end
  endtask

  // Drop valid and let every outstanding request come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TILE_PIXELS) tile_set = value[TILE_W-1:0];
    else pages_set = value[PAGES_W-1:0];
  endtask

  task automatic set_tile(input logic [CFG_DATA_W-1:0] value);
    int unsigned need;
    bit          covered;
    need = tile_limit(value[TILE_W-1:0]);
    covered = 1'b1;
    for (int p = 0; p < need; p++) if (!written[p]) covered = 1'b0;
    if (track_page != 0 && !covered) begin
      // close the running average so the larger tile opens on a first page
      write_reg(REG_PAGE_TOTAL, 13'd1);
      while (track_page != 0) send_pixel(pick_pixel());
      settle();
    end
    write_reg(REG_TILE_PIXELS, value);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] tiles,
                           input logic [CFG_DATA_W-1:0] pages);
    settle();
    set_tile(tiles);
    write_reg(REG_PAGE_TOTAL, pages);
    settings_used++;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] tiles,
                           input logic [CFG_DATA_W-1:0] pages,
                           input int send_pct, input int stall_pct, input int count);
    configure(tiles, pages);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    dark_level = 16'($urandom_range(65535, 0));
    repeat (count) send_pixel(pick_pixel());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset sizes: first page stores the samples as they are.
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    // Shrink the tile below the current position; upper data bits of the page
    // total are masked, leaving three pages.
    configure(13'd2, 13'h1803);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'h1234);
    send_pixel(16'h5678);
    // Zero sizes act as one; the page count already past the limit wraps.
    configure(13'd0, 13'd0);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'h8001);
    // Oversized settings clamp to the maximum.
    configure(13'h1FFF, 13'h07FF);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    // Tile shrinks under the position mid-page, then two pages per run.
    configure(13'd3, 13'd2);
    send_pixel(16'h0F0F);
    send_pixel(16'hF0F0);
    send_pixel(16'h0001);
    send_pixel(16'hFFFE);
    send_pixel(16'h4000);

    run_phase(13'd16,   13'd8,    0,  0,  80);
    run_phase(13'd5,    13'h0400, 81, 0,  60);
    run_phase(13'd1,    13'd2,    0,  81, 40);
    run_phase(13'd40,   13'd3,    16, 16, 80);
    run_phase(13'h1000, 13'd0,    81, 0,  40);
    run_phase(13'h1001, 13'd5,    0,  81, 30);
    run_phase(13'd6,    13'd3,    16, 16, 40);
    run_phase(13'd9,    13'h07FF, 0,  0,  30);

    // One pixel over a 128-page run of mostly full-scale samples: wide
    // divisors, the last-page flag and the wrap.
    configure(13'd1, 13'h0080);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    repeat (130) send_pixel(($urandom_range(3, 0) == 0) ? pick_pixel() : 16'hFFFF);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d pixel results over %0d register settings,", checked, settings_used);
    $display("with sender gaps and result stalls mixed across the phases.");
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/prmd_pkg.sv
rtl/prmd_ram.sv
rtl/pixel_running_mean_deviation.sv
sim/dark_deviation_checker.sv
sim/pixel_running_mean_deviation_tb.sv
